// ===== hdl/kpc_pkg.sv =====
// Shared types and constants for the key press classifier.
package kpc_pkg;

   localparam int unsigned DEBOUNCE_WIDTH = 8;
   localparam int unsigned HOLD_WIDTH     = 16;
   localparam int unsigned CSR_DATA_WIDTH = 16;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_LIMIT_RESET = 8'd20;
   localparam logic [HOLD_WIDTH-1:0]     LONG_PRESS_LIMIT_RESET = 16'd1000;
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_MAX = 8'hFF;
   localparam logic [HOLD_WIDTH-1:0]     HOLD_MAX = 16'hFFFF;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_DEBOUNCE_LIMIT   = 1'b0,
      REG_LONG_PRESS_LIMIT = 1'b1
   } reg_index_type;

   typedef enum logic {
      KIND_TICK = 1'b0,
      KIND_EDGE = 1'b1
   } item_kind_type;

   typedef enum logic [1:0] {
      PRESS_NONE  = 2'd0,
      PRESS_SHORT = 2'd1,
      PRESS_LONG  = 2'd2
   } press_event_type;

   typedef struct packed {
      logic [DEBOUNCE_WIDTH-1:0] debounce_count;
      logic [HOLD_WIDTH-1:0]     hold_timer;
      logic                      press_valid;
      logic                      long_seen;
      logic                      ticks_enabled;
      press_event_type           status_latch;
   } state_type;

   typedef struct packed {
      press_event_type press_event;
      press_event_type latched_status;
      logic            armed;
   } result_type;

endpackage

// ===== hdl/kpc_engine.sv =====
// Classifier state, configuration registers and per-item next-state logic.
module kpc_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [kpc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [kpc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   input  logic                                 item_accept,
   input  logic                                 item_kind,
   input  logic                                 item_key_down,
   output kpc_pkg::result_type                  item_result
);

   logic [kpc_pkg::DEBOUNCE_WIDTH-1:0] debounce_limit_ff;
   logic [kpc_pkg::HOLD_WIDTH-1:0]     long_press_limit_ff;
   kpc_pkg::state_type                 state_ff;
   kpc_pkg::state_type                 state_in;
   kpc_pkg::press_event_type           press_event;

   always_comb begin
      state_in    = state_ff;
      press_event = kpc_pkg::PRESS_NONE;
      if (item_kind == kpc_pkg::KIND_EDGE) begin
         state_in.ticks_enabled = 1'b1;
      end else if (state_ff.ticks_enabled) begin
         if (item_key_down) begin
            if (state_ff.debounce_count <= debounce_limit_ff) begin
               if (state_ff.debounce_count != kpc_pkg::DEBOUNCE_MAX) begin
                  state_in.debounce_count = state_ff.debounce_count + 1'b1;
               end
            end else begin
               state_in.press_valid = 1'b1;
               if (!state_ff.long_seen && state_ff.hold_timer != kpc_pkg::HOLD_MAX) begin
                  state_in.hold_timer = state_ff.hold_timer + 1'b1;
               end
            end
         end else begin
            state_in.debounce_count = '0;
            if (state_ff.press_valid) begin
               if (!state_ff.long_seen) begin
                  state_in.status_latch  = kpc_pkg::PRESS_SHORT;
                  state_in.ticks_enabled = 1'b0;
                  press_event            = kpc_pkg::PRESS_SHORT;
               end
               state_in.press_valid = 1'b0;
               state_in.long_seen   = 1'b0;
               state_in.hold_timer  = '0;
            end
         end
         // long press check sees the timer after this tick's update
         if (state_in.hold_timer > long_press_limit_ff) begin
            state_in.status_latch   = kpc_pkg::PRESS_LONG;
            state_in.ticks_enabled  = 1'b0;
            state_in.long_seen      = 1'b1;
            state_in.debounce_count = '0;
            state_in.hold_timer     = '0;
            press_event             = kpc_pkg::PRESS_LONG;
         end
      end
   end

   always_comb begin
      item_result.press_event    = press_event;
      item_result.latched_status = state_in.status_latch;
      item_result.armed          = state_in.ticks_enabled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_limit_ff   <= kpc_pkg::DEBOUNCE_LIMIT_RESET;
         long_press_limit_ff <= kpc_pkg::LONG_PRESS_LIMIT_RESET;
         state_ff            <= '0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               kpc_pkg::REG_DEBOUNCE_LIMIT: begin
                  debounce_limit_ff <= csr_wdata[kpc_pkg::DEBOUNCE_WIDTH-1:0];
               end
               kpc_pkg::REG_LONG_PRESS_LIMIT: begin
                  long_press_limit_ff <= csr_wdata[kpc_pkg::HOLD_WIDTH-1:0];
               end
               default: begin
               end
            endcase
         end
         if (item_accept) begin
            state_ff <= state_in;
         end
      end
   end

endmodule

// ===== hdl/key_press_classifier_top.sv =====
// Top level of the key press classifier: handshake, engine and result register.
// Debounced key press classifier. Each request transaction is either a key edge
// (req_kind = 1), which arms the block, or a 1 ms tick (req_kind = 0) carrying
// the sampled key level in req_key_down. Every request gives exactly one response
// transaction: rsp_press_event reports a short (1) or long (2) press detected by
// that request, rsp_latched_status the last press reported so far, and rsp_armed
// whether ticks are processed after it. A press is valid once the debounce count
// exceeds debounce_limit (register 0, reset 20); a long press is reported once the
// hold timer exceeds long_press_limit (register 1, reset 1000). Either report
// disarms the block. Throughput is one transaction per clock while the response
// side does not stall: the whole state update is one pass of counter and compare
// logic between the state registers, and the response appears in the cycle after
// acceptance in a single result register. A request is taken even while that
// register holds a response, as long as the response is being taken in the same
// cycle. Write the registers only while no transaction is in flight.
module key_press_classifier_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [kpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [kpc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic                                req_key_down,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_press_event,
   output logic [1:0]                          rsp_latched_status,
   output logic                                rsp_armed
);

   logic                req_accept;
   kpc_pkg::result_type item_result;
   kpc_pkg::result_type rsp_data_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   // stall only while a held response is not being taken
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   kpc_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .item_accept   (req_accept),
      .item_kind     (req_kind),
      .item_key_down (req_key_down),
      .item_result   (item_result)
   );

   // hold the response while stalled, load a new one on every accepted request
   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= item_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_press_event    = rsp_data_ff.press_event;
   assign rsp_latched_status = rsp_data_ff.latched_status;
   assign rsp_armed          = rsp_data_ff.armed;

endmodule

// ===== hdl/kpc_checker.sv =====
// Port-level checks for the key press classifier, bound to the top level.
module kpc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_press_event,
   input logic [1:0] rsp_latched_status,
   input logic       rsp_armed
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_event_disarms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_press_event != kpc_pkg::PRESS_NONE |-> !rsp_armed)
      else $error("press reported but block still armed");

   a_event_latched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_press_event != kpc_pkg::PRESS_NONE
         |-> rsp_latched_status == rsp_press_event)
      else $error("reported press not latched");

   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_press_event == kpc_pkg::PRESS_NONE
                  || rsp_press_event == kpc_pkg::PRESS_SHORT
                  || rsp_press_event == kpc_pkg::PRESS_LONG))
      else $error("press event code out of range");

endmodule

bind key_press_classifier_top kpc_checker u_kpc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_press_event    (rsp_press_event),
   .rsp_latched_status (rsp_latched_status),
   .rsp_armed          (rsp_armed)
);

// ===== tb/sv/key_press_classifier_top_tb.sv =====
// Self-checking testbench for the key press classifier top level.
module key_press_classifier_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Generous bound on the run, far above the slowest legal run under the
   // longest stalls.
   localparam int CYCLE_LIMIT = 100_000;
   // Base count of random transactions that the block acts on; each random phase runs a share of it.
   localparam int RANDOM_ITEMS = 200;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_wen = 1'b0;
   logic [kpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [kpc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic                                req_kind = 1'b0;
   logic                                req_key_down = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [1:0]                          rsp_press_event;
   logic [1:0]                          rsp_latched_status;
   logic                                rsp_armed;

   key_press_classifier_top uut (
      .clock              (clock),
      .reset              (reset),
      .csr_wen            (csr_wen),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_key_down       (req_key_down),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_press_event    (rsp_press_event),
      .rsp_latched_status (rsp_latched_status),
      .rsp_armed          (rsp_armed)
   );

   // Predicted classifier state and register copies, reset values from the package.
   logic [kpc_pkg::DEBOUNCE_WIDTH-1:0] bounce_count = '0;
   logic [kpc_pkg::HOLD_WIDTH-1:0]     hold_ticks   = '0;
   logic                               press_ok     = 1'b0;
   logic                               long_held    = 1'b0;
   logic                               ticks_on     = 1'b0;
   kpc_pkg::press_event_type           status_now   = kpc_pkg::PRESS_NONE;
   logic [kpc_pkg::DEBOUNCE_WIDTH-1:0] debounce_lim = kpc_pkg::DEBOUNCE_LIMIT_RESET;
   logic [kpc_pkg::HOLD_WIDTH-1:0]     long_lim     = kpc_pkg::LONG_PRESS_LIMIT_RESET;

   kpc_pkg::result_type expected_q[$];

   int  errors       = 0;
   int  responses    = 0;
   int  short_events = 0;
   int  long_events  = 0;
   int  live_items   = 0;
   int  cycle_count  = 0;
   int  phases_run   = 0;
   // Set to switch off idling on both sides for a long stretch.
   logic no_idle = 1'b0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Advance the predicted state by one transaction and return the response
   // that transaction must produce.
   function automatic kpc_pkg::result_type classify_key(input kpc_pkg::item_kind_type kind,
                                                        input logic key);
      kpc_pkg::result_type      r;
      kpc_pkg::press_event_type ev;
      ev = kpc_pkg::PRESS_NONE;
      if (kind == kpc_pkg::KIND_EDGE) begin
         ticks_on = 1'b1;
      end else if (ticks_on) begin
         if (key) begin
            if (bounce_count <= debounce_lim) begin
               // debounce counter saturates at its top
               if (bounce_count != kpc_pkg::DEBOUNCE_MAX) bounce_count = bounce_count + 1'b1;
            end else begin
               press_ok = 1'b1;
               // hold timer freezes after a long press and saturates at its top
               if (!long_held && hold_ticks != kpc_pkg::HOLD_MAX) hold_ticks = hold_ticks + 1'b1;
            end
         end else begin
            bounce_count = '0;
            if (press_ok) begin
               // a release after a long press only clears the press state
               if (!long_held) begin
                  status_now = kpc_pkg::PRESS_SHORT;
                  ticks_on   = 1'b0;
                  ev         = kpc_pkg::PRESS_SHORT;
               end
               press_ok   = 1'b0;
               long_held  = 1'b0;
               hold_ticks = '0;
            end
         end
         if (hold_ticks > long_lim) begin
            status_now   = kpc_pkg::PRESS_LONG;
            ticks_on     = 1'b0;
            long_held    = 1'b1;
            bounce_count = '0;
            hold_ticks   = '0;
            ev           = kpc_pkg::PRESS_LONG;
         end
      end
      r.press_event    = ev;
      r.latched_status = status_now;
      r.armed          = ticks_on;
      return r;
   endfunction

   // Response side: random stall, except during the no-idle stretch.
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 17);
   end

   // Check each response against the oldest prediction, then record the
   // prediction for a request accepted at this edge.
   always @(posedge clock) begin : scoreboard
      kpc_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses++;
         if (rsp_press_event == kpc_pkg::PRESS_SHORT) short_events++;
         if (rsp_press_event == kpc_pkg::PRESS_LONG) long_events++;
         if (expected_q.size() == 0) begin
            $display("%0t ns: unexpected response, event %0d status %0d armed %0d",
                     $time, rsp_press_event, rsp_latched_status, rsp_armed);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_press_event !== want.press_event) begin
               $display("%0t ns: rsp_press_event expected %0d, actual %0d",
                        $time, want.press_event, rsp_press_event);
               errors++;
            end
            if (rsp_latched_status !== want.latched_status) begin
               $display("%0t ns: rsp_latched_status expected %0d, actual %0d",
                        $time, want.latched_status, rsp_latched_status);
               errors++;
            end
            if (rsp_armed !== want.armed) begin
               $display("%0t ns: rsp_armed expected %0d, actual %0d",
                        $time, want.armed, rsp_armed);
               errors++;
            end
         end
      end
      if (!reset && req_valid && !req_stall) begin
         // ticks that arrive while disarmed are ignored and do not count
         if (req_kind == kpc_pkg::KIND_EDGE || ticks_on) live_items++;
         expected_q.push_back(classify_key(kpc_pkg::item_kind_type'(req_kind), req_key_down));
      end
   end

   // Watchdog: end the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_q.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Send one request transaction after a random gap; return once it is taken.
   task automatic send_item(input kpc_pkg::item_kind_type kind, input logic key);
      int gap;
      gap = 0;
      while (!no_idle && gap < 12 && $urandom_range(99) < 17) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_key_down <= key;
      do @(posedge clock); while (req_stall);
   endtask

   // Send n ticks with the key held down.
   task automatic hold_key(input int n);
      repeat (n) send_item(kpc_pkg::KIND_TICK, 1'b1);
   endtask

   // Hold off requests until every predicted response has been taken, then let
   // the response register settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // Write one register; call only while nothing is in flight.
   task automatic write_reg(input kpc_pkg::reg_index_type idx,
                            input logic [kpc_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == kpc_pkg::REG_DEBOUNCE_LIMIT) debounce_lim = value[kpc_pkg::DEBOUNCE_WIDTH-1:0];
      else long_lim = value;
      @(posedge clock);
   endtask

   // Ticks before any edge must be ignored.
   task automatic test_disarmed_ticks();
      send_item(kpc_pkg::KIND_TICK, 1'b0);
      send_item(kpc_pkg::KIND_TICK, 1'b1);
   endtask

   // Short press with the reset limits; another edge while armed changes nothing.
   task automatic test_reset_limits();
      send_item(kpc_pkg::KIND_EDGE, 1'b0);
      send_item(kpc_pkg::KIND_EDGE, 1'b1);
      hold_key(kpc_pkg::DEBOUNCE_LIMIT_RESET + 2);
      send_item(kpc_pkg::KIND_TICK, 1'b0);
   endtask

   // Both limits at zero: long press, re-arm while held, release after long press.
   task automatic test_zero_limits();
      wait_drained();
      // upper data bits are don't-care for the debounce register
      write_reg(kpc_pkg::REG_DEBOUNCE_LIMIT, 16'hFF00);
      write_reg(kpc_pkg::REG_LONG_PRESS_LIMIT, 16'h0000);
      send_item(kpc_pkg::KIND_EDGE, 1'b1);
      hold_key(3);
      send_item(kpc_pkg::KIND_EDGE, 1'b0);
      hold_key(3);
      send_item(kpc_pkg::KIND_TICK, 1'b0);
      // bounce: release before the press becomes valid
      send_item(kpc_pkg::KIND_TICK, 1'b1);
      send_item(kpc_pkg::KIND_TICK, 1'b0);
      hold_key(2);
      send_item(kpc_pkg::KIND_TICK, 1'b0);
   endtask

   // Small limits: one short press and one long press.
   task automatic test_short_then_long();
      wait_drained();
      write_reg(kpc_pkg::REG_DEBOUNCE_LIMIT, 16'h0002);
      write_reg(kpc_pkg::REG_LONG_PRESS_LIMIT, 16'h0003);
      send_item(kpc_pkg::KIND_EDGE, 1'b0);
      hold_key(4);
      send_item(kpc_pkg::KIND_TICK, 1'b0);
      send_item(kpc_pkg::KIND_EDGE, 1'b0);
      hold_key(7);
      send_item(kpc_pkg::KIND_TICK, 1'b0);
   endtask

   // Debounce counter saturation: never valid at the top limit; drop the limit
   // by one with the key still held so the saturated counter makes it valid.
   // Run without idling.
   task automatic test_debounce_saturation();
      wait_drained();
      no_idle = 1'b1;
      write_reg(kpc_pkg::REG_DEBOUNCE_LIMIT, 16'h00FF);
      write_reg(kpc_pkg::REG_LONG_PRESS_LIMIT, 16'h0005);
      send_item(kpc_pkg::KIND_EDGE, 1'b1);
      hold_key(260);
      wait_drained();
      write_reg(kpc_pkg::REG_DEBOUNCE_LIMIT, 16'h00FE);
      hold_key(2);
      send_item(kpc_pkg::KIND_TICK, 1'b0);
      no_idle = 1'b0;
   endtask

   // One random press: mostly an edge, a held stretch around the limits and a
   // release; now and then a stray transaction, a contact bounce or a re-arm.
   task automatic random_press();
      int span;
      int held;
      if ($urandom_range(99) < 12) begin
         send_item(kpc_pkg::item_kind_type'($urandom_range(1)), 1'($urandom_range(1)));
         return;
      end
      span = (debounce_lim > 40 ? 40 : int'(debounce_lim))
           + (long_lim > 40 ? 40 : int'(long_lim)) + 4;
      held = $urandom_range(span);
      send_item(kpc_pkg::KIND_EDGE, 1'($urandom_range(1)));
      repeat (held) begin
         case ($urandom_range(39))
            0:       send_item(kpc_pkg::KIND_TICK, 1'b0);
            1:       send_item(kpc_pkg::KIND_EDGE, 1'($urandom_range(1)));
            default: send_item(kpc_pkg::KIND_TICK, 1'b1);
         endcase
      end
      send_item(kpc_pkg::KIND_TICK, 1'b0);
   endtask

   // One random phase with fixed limits; pause once mid-phase if asked.
   task automatic random_phase(input int db, input int lp, input int n, input bit pause);
      int stop_at;
      wait_drained();
      write_reg(kpc_pkg::REG_DEBOUNCE_LIMIT, {8'($urandom_range(255)), 8'(db)});
      write_reg(kpc_pkg::REG_LONG_PRESS_LIMIT, 16'(lp));
      phases_run++;
      stop_at = live_items + n;
      while (live_items < stop_at) begin
         random_press();
         if (pause && live_items >= stop_at - n / 2) begin
            // hold the sender until every outstanding response is back
            wait_drained();
            pause = 1'b0;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_disarmed_ticks();
      test_reset_limits();
      test_zero_limits();
      test_short_then_long();
      test_debounce_saturation();

      random_phase(0,     0,     RANDOM_ITEMS * 3 / 20, 1'b0);
      random_phase(1,     3,     RANDOM_ITEMS * 3 / 20, 1'b1);
      random_phase(4,     9,     RANDOM_ITEMS * 3 / 20, 1'b0);
      random_phase(255,   2,     RANDOM_ITEMS / 10,     1'b0);
      random_phase(2,     65534, RANDOM_ITEMS / 10,     1'b0);
      random_phase(254,   0,     RANDOM_ITEMS / 20,     1'b0);
      random_phase(9,     25,    RANDOM_ITEMS * 3 / 20, 1'b0);
      random_phase(20,    1000,  RANDOM_ITEMS / 10,     1'b0);

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Checked %0d responses: %0d short and %0d long presses reported",
               responses, short_events, long_events);
      $display("Covered reset limits, zero and top limits, counter saturation and %0d random phases",
               phases_run);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/kpc_pkg.sv
hdl/kpc_engine.sv
hdl/key_press_classifier_top.sv
hdl/kpc_checker.sv
tb/sv/key_press_classifier_top_tb.sv
